// File: src/dews_pkg.sv
// Package for the double-ended queue with search.
// Holds the request and status codes, the controller states and default sizes.
// No dependencies; used by the top level.
package dews_pkg;

  // Default sizes of the entry store.
  localparam int unsigned DefaultDepth      = 16;
  localparam int unsigned DefaultValueWidth = 32;

  // Fixed field widths on the stream ports.
  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned ItemWidth   = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 5;

  // Request codes carried in the input tuser.
  typedef enum logic [OpcodeWidth-1:0] {
    OP_INSERT_FRONT = 3'd0,
    OP_INSERT_BACK  = 3'd1,
    OP_REMOVE_FRONT = 3'd2,
    OP_REMOVE_BACK  = 3'd3,
    OP_SEARCH       = 3'd4
  } opcode_e;

  // Result status codes carried in the output tuser.
  typedef enum logic [StatusWidth-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

endpackage

// File: src/dews_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dews_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/double_ended_queue_with_search.sv
// Top level of the double-ended queue with search.
// Holds the pointer and count registers, the request sequencer and the result register.
// Depends on dews_pkg and dews_ram.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the opcode (insert front,
//   insert back, remove front, remove back, search) and tdata the value. Each
//   request yields exactly one result beat on the m_axis channel with a status,
//   a found flag, the entry count after the request and an empty flag.
//   For inserts, removals and unknown opcodes the result is registered at the
//   accepting edge. A search reads the entry store one entry per cycle from the
//   front, through the single read port of the RAM, and stops at the first match
//   or after the last held entry. A search of an empty queue reads nothing; its
//   result is registered at the accepting edge. While a search runs no new
//   request is accepted.
//   The result register lets a new request be taken while the previous result
//   waits, as long as that result leaves in the same cycle; when the receiver
//   stalls, the result holds and s_axis_tready stays low.
//   Reset empties the queue (front slot zero, count zero) and clears the
//   result valid flag. The entry store is not cleared; only held entries are read.
module double_ended_queue_with_search #(
  parameter int unsigned DEPTH       = dews_pkg::DefaultDepth,
  parameter int unsigned VALUE_WIDTH = dews_pkg::DefaultValueWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: item_value[31:0]
  input  logic [dews_pkg::ItemWidth-1:0]    s_axis_tdata,
  // tuser: opcode[2:0]
  input  logic [dews_pkg::OpcodeWidth-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: found[0], entry_count[5:1], is_empty[6], zero[7]
  output logic [7:0]                        m_axis_tdata,
  // tuser: status[1:0]
  output logic [dews_pkg::StatusWidth-1:0]  m_axis_tuser
);

  localparam int unsigned IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = ((IW > CW) ? IW : CW) + 1;
  localparam int unsigned ExW = 64;

  // Controller and pointer state.
  dews_pkg::state_e state_q, state_d;
  logic [IW-1:0]          front_q, front_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          slot_q, slot_d;
  logic [CW-1:0]          off_q, off_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  dews_pkg::status_e              out_status_q, out_status_d;
  logic                           out_found_q, out_found_d;
  logic [dews_pkg::CountWidth-1:0] out_count_q, out_count_d;
  logic                           out_empty_q, out_empty_d;

  // RAM port signals.
  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Derived signals.
  logic                   in_accept;
  logic                   out_free;
  logic                   load;
  logic                   is_full;
  logic [ExW-1:0]         in_ext;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [IW-1:0]          front_prev;
  logic [IW-1:0]          front_next;
  logic [IW-1:0]          back_slot;
  logic [SW-1:0]          back_sum;
  logic [IW-1:0]          slot_next;
  dews_pkg::opcode_e      opcode;

  dews_ram #(
    .Width (VALUE_WIDTH),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_d),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Value kept as its low VALUE_WIDTH bits, zero-extended when the store is wider.
  assign in_ext   = {{(ExW - dews_pkg::ItemWidth){1'b0}}, s_axis_tdata};
  assign in_value = in_ext[VALUE_WIDTH-1:0];
  assign opcode   = dews_pkg::opcode_e'(s_axis_tuser);

  // Ring arithmetic on slot numbers.
  assign front_prev = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign front_next = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
  assign slot_next  = (slot_q == IW'(DEPTH - 1)) ? '0 : slot_q + IW'(1);
  assign back_sum   = SW'(front_q) + SW'(count_q);
  assign back_slot  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
  assign is_full    = (count_q == CW'(DEPTH));

  // The result register is free when empty or when its beat leaves now.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == dews_pkg::ST_IDLE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Sequencer: next state, pointers, RAM accesses and result.
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    slot_d       = slot_q;
    off_d        = off_q;
    key_d        = key_q;
    ram_we       = 1'b0;
    ram_waddr    = back_slot;
    ram_re       = 1'b0;
    ram_raddr    = slot_q;
    load         = 1'b0;
    out_status_d = dews_pkg::STATUS_DONE;
    out_found_d  = 1'b0;
    unique case (state_q)
      dews_pkg::ST_IDLE: begin
        if (in_accept) begin
          key_d = in_value;
          load  = 1'b1;
          case (opcode)
            dews_pkg::OP_INSERT_FRONT: begin
              if (is_full) begin
                out_status_d = dews_pkg::STATUS_FULL;
              end else begin
                front_d   = front_prev;
                ram_we    = 1'b1;
                ram_waddr = front_prev;
                count_d   = count_q + CW'(1);
              end
            end
            dews_pkg::OP_INSERT_BACK: begin
              if (is_full) begin
                out_status_d = dews_pkg::STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            dews_pkg::OP_REMOVE_FRONT: begin
              if (count_q == '0) begin
                out_status_d = dews_pkg::STATUS_EMPTY;
              end else begin
                front_d = front_next;
                count_d = count_q - CW'(1);
              end
            end
            dews_pkg::OP_REMOVE_BACK: begin
              if (count_q == '0) begin
                out_status_d = dews_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            dews_pkg::OP_SEARCH: begin
              // Start with the front entry; an empty queue answers at once.
              if (count_q != '0) begin
                load      = 1'b0;
                ram_re    = 1'b1;
                ram_raddr = front_q;
                slot_d    = front_next;
                off_d     = CW'(1);
                state_d   = dews_pkg::ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dews_pkg::ST_SEARCH: begin
        // Compare the entry read last cycle; fetch the next one if needed.
        if (ram_rdata == key_q) begin
          load        = 1'b1;
          out_found_d = 1'b1;
          state_d     = dews_pkg::ST_IDLE;
        end else if (off_q == count_q) begin
          load    = 1'b1;
          state_d = dews_pkg::ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_q;
          slot_d    = slot_next;
          off_d     = off_q + CW'(1);
        end
      end
      default: begin
        state_d = dews_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register contents.
  assign out_count_d = dews_pkg::CountWidth'(count_d);
  assign out_empty_d = (count_d == '0);
  assign out_valid_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dews_pkg::ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Search cursor and key.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    off_q  <= off_d;
    key_q  <= key_d;
  end

  // Result payload, loaded when a request completes.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_count_q  <= out_count_d;
      out_empty_q  <= out_empty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_empty_q, out_count_q, out_found_q};
  assign m_axis_tuser  = out_status_q;

endmodule
